// ===== hw/rtl/dcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Drawing command decoder package
// Shared types and codes for the byte front end, the command queue and the
// executing back end.
// ----------------------------------------------------------------------------
package dcd_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Short opcodes, top two bits of a byte.
	localparam logic [1:0] SOP_DX  = 2'd0;
	localparam logic [1:0] SOP_DY  = 2'd1;
	localparam logic [1:0] SOP_DT  = 2'd2;
	localparam logic [1:0] SOP_EXT = 2'd3;

	// Extended opcodes.
	localparam logic [3:0] XOP_DX     = 4'd0;
	localparam logic [3:0] XOP_DY     = 4'd1;
	localparam logic [3:0] XOP_DT     = 4'd2;
	localparam logic [3:0] XOP_PEN    = 4'd3;
	localparam logic [3:0] XOP_CLEAR  = 4'd4;
	localparam logic [3:0] XOP_KEY    = 4'd5;
	localparam logic [3:0] XOP_COLOUR = 4'd6;

	// Extension byte count code that stands for four bytes.
	localparam logic [1:0] COUNT_CODE_FOUR = 2'd3;

	// Result kinds.
	localparam logic [2:0] KIND_LINE   = 3'd0;
	localparam logic [2:0] KIND_PAUSE  = 3'd1;
	localparam logic [2:0] KIND_CLEAR  = 3'd2;
	localparam logic [2:0] KIND_KEY    = 3'd3;
	localparam logic [2:0] KIND_COLOUR = 3'd4;
	localparam logic [2:0] KIND_ERROR  = 3'd5;

	typedef enum logic [2:0] {
		CMD_MOVE_X = 3'd0,
		CMD_MOVE_Y = 3'd1,
		CMD_PAUSE  = 3'd2,
		CMD_PEN    = 3'd3,
		CMD_CLEAR  = 3'd4,
		CMD_KEY    = 3'd5,
		CMD_COLOUR = 3'd6,
		CMD_ERROR  = 3'd7
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== hw/rtl/dcd_front.sv =====
// ----------------------------------------------------------------------------
// Drawing command decoder front end
// Accepts stream bytes, collects extension operands and pushes decoded
// commands into the queue. Halts on an unknown extended opcode.
// ----------------------------------------------------------------------------
module dcd_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  logic [7:0]             stream_byte,
	input  dcd_pkg::queue_status_t queue_status,
	output logic                   push,
	output dcd_pkg::cmd_t          push_cmd
);
	import dcd_pkg::*;

	logic [2:0] rem_q;
	logic [2:0] cnt_q;
	logic [3:0] op_q;
	logic [7:0] buf_q [4];
	logic       halted_q;

	logic        accept;
	logic        work;
	logic [1:0]  idx;
	logic [7:0]  buf_n [4];
	logic [31:0] packed_buf;
	logic [31:0] ext_operand;
	logic [2:0]  new_cnt;
	logic [3:0]  run_op;
	logic [2:0]  run_cnt;
	logic        run_ext;
	logic        has_cmd;
	cmd_t        cmd;

	assign byte_stall = !halted_q && queue_status.full;
	assign accept     = byte_valid && !byte_stall;
	assign work       = accept && !halted_q;
	assign idx        = 2'(cnt_q - rem_q);
	assign new_cnt    = (stream_byte[5:4] == COUNT_CODE_FOUR) ? 3'd4 : {1'b0, stream_byte[5:4]};

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			buf_n[i] = buf_q[i];
		end
		if (rem_q != 3'd0) begin
			buf_n[idx] = stream_byte;
		end else begin
			for (int i = 0; i < 4; i++) begin
				buf_n[i] = 8'd0;
			end
		end
	end

	assign packed_buf = {buf_n[0], buf_n[1], buf_n[2], buf_n[3]};

	always_comb begin
		if (rem_q != 3'd0) begin
			run_ext = (rem_q == 3'd1);
			run_op  = op_q;
			run_cnt = cnt_q;
		end else begin
			run_ext = (stream_byte[7:6] == SOP_EXT) && (new_cnt == 3'd0);
			run_op  = stream_byte[3:0];
			run_cnt = new_cnt;
		end
	end

	always_comb begin
		case (run_cnt)
			3'd1:    ext_operand = {24'd0, packed_buf[31:24]};
			3'd2:    ext_operand = {{16{packed_buf[31]}}, packed_buf[31:16]};
			3'd4:    ext_operand = packed_buf;
			default: ext_operand = 32'd0;
		endcase
	end

	always_comb begin
		cmd.op    = CMD_MOVE_X;
		cmd.value = ext_operand;
		has_cmd   = 1'b0;
		if (run_ext) begin
			has_cmd = 1'b1;
			case (run_op)
				XOP_DX:     cmd.op = CMD_MOVE_X;
				XOP_DY:     cmd.op = CMD_MOVE_Y;
				XOP_DT:     cmd.op = CMD_PAUSE;
				XOP_PEN:    cmd.op = CMD_PEN;
				XOP_CLEAR:  cmd.op = CMD_CLEAR;
				XOP_KEY:    cmd.op = CMD_KEY;
				XOP_COLOUR: begin
					cmd.op    = CMD_COLOUR;
					cmd.value = packed_buf;
				end
				default:    cmd.op = CMD_ERROR;
			endcase
		end else if (rem_q == 3'd0) begin
			case (stream_byte[7:6])
				SOP_DX: begin
					has_cmd   = 1'b1;
					cmd.op    = CMD_MOVE_X;
					cmd.value = {{26{stream_byte[5]}}, stream_byte[5:0]};
				end
				SOP_DY: begin
					has_cmd   = 1'b1;
					cmd.op    = CMD_MOVE_Y;
					cmd.value = {{26{stream_byte[5]}}, stream_byte[5:0]};
				end
				SOP_DT: begin
					has_cmd   = 1'b1;
					cmd.op    = CMD_PAUSE;
					cmd.value = {26'd0, stream_byte[5:0]};
				end
				default: has_cmd = 1'b0;
			endcase
		end
	end

	assign push     = work && has_cmd;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 3'd0;
			cnt_q    <= 3'd0;
			op_q     <= 4'd0;
			halted_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				buf_q[i] <= 8'd0;
			end
		end else if (work) begin
			for (int i = 0; i < 4; i++) begin
				buf_q[i] <= buf_n[i];
			end
			if (rem_q != 3'd0) begin
				rem_q <= rem_q - 3'd1;
			end else if (stream_byte[7:6] == SOP_EXT) begin
				rem_q <= new_cnt;
				cnt_q <= new_cnt;
				op_q  <= stream_byte[3:0];
			end
			if (has_cmd && cmd.op == CMD_ERROR) begin
				halted_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/dcd_queue.sv =====
// ----------------------------------------------------------------------------
// Drawing command decoder command queue
// A short first-in first-out queue of decoded commands between the front
// and back ends.
// ----------------------------------------------------------------------------
module dcd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  dcd_pkg::cmd_t          push_cmd,
	input  logic                   pop,
	output dcd_pkg::cmd_t          head_cmd,
	output dcd_pkg::queue_status_t status
);
	import dcd_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign status.full  = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/dcd_back.sv =====
// ----------------------------------------------------------------------------
// Drawing command decoder back end
// Executes queued commands against the cursor, stored point and pen, and
// holds each result in an output register until it is transferred.
// ----------------------------------------------------------------------------
module dcd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcd_pkg::cmd_t          head_cmd,
	input  dcd_pkg::queue_status_t queue_status,
	output logic                   pop,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic [2:0]             command_kind,
	output logic signed [31:0]     x_start,
	output logic signed [31:0]     y_start,
	output logic signed [31:0]     x_end,
	output logic signed [31:0]     y_end,
	output logic signed [35:0]     pause_ms,
	output logic [31:0]            rgba_colour
);
	import dcd_pkg::*;

	logic [31:0] cursor_x_q;
	logic [31:0] cursor_y_q;
	logic [31:0] stored_x_q;
	logic [31:0] stored_y_q;
	logic        pen_q;
	logic        valid_q;
	logic [2:0]  kind_q;
	logic [31:0] x_start_q;
	logic [31:0] y_start_q;
	logic [31:0] x_end_q;
	logic [31:0] y_end_q;
	logic [35:0] pause_q;
	logic [31:0] rgba_q;

	logic        emits;
	logic        out_free;
	logic [31:0] next_y;
	logic [35:0] wide;
	logic [35:0] pause_n;
	logic [2:0]  kind_n;

	assign next_y  = cursor_y_q + head_cmd.value;
	assign wide    = {{4{head_cmd.value[31]}}, head_cmd.value};
	assign pause_n = (wide << 3) + (wide << 1);

	always_comb begin
		emits  = 1'b1;
		kind_n = KIND_LINE;
		case (head_cmd.op)
			CMD_MOVE_X: emits = 1'b0;
			CMD_MOVE_Y: emits = pen_q;
			CMD_PAUSE:  kind_n = KIND_PAUSE;
			CMD_PEN:    emits = 1'b0;
			CMD_CLEAR:  kind_n = KIND_CLEAR;
			CMD_KEY:    kind_n = KIND_KEY;
			CMD_COLOUR: kind_n = KIND_COLOUR;
			default:    kind_n = KIND_ERROR;
		endcase
	end

	assign out_free = !valid_q || !result_stall;
	assign pop      = !queue_status.empty && (out_free || !emits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= 32'd0;
			cursor_y_q <= 32'd0;
			stored_x_q <= 32'd0;
			stored_y_q <= 32'd0;
			pen_q      <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				case (head_cmd.op)
					CMD_MOVE_X: cursor_x_q <= cursor_x_q + head_cmd.value;
					CMD_MOVE_Y: begin
						cursor_y_q <= next_y;
						stored_x_q <= cursor_x_q;
						stored_y_q <= next_y;
					end
					CMD_PEN:    pen_q <= !pen_q;
					default:    pen_q <= pen_q;
				endcase
			end
			if (pop && emits) begin
				valid_q <= 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emits) begin
			kind_q    <= kind_n;
			x_start_q <= 32'd0;
			y_start_q <= 32'd0;
			x_end_q   <= 32'd0;
			y_end_q   <= 32'd0;
			pause_q   <= 36'd0;
			rgba_q    <= 32'd0;
			case (head_cmd.op)
				CMD_MOVE_Y: begin
					x_start_q <= stored_x_q;
					y_start_q <= stored_y_q;
					x_end_q   <= cursor_x_q;
					y_end_q   <= next_y;
				end
				CMD_PAUSE:  pause_q <= pause_n;
				CMD_COLOUR: rgba_q  <= head_cmd.value;
				default:    rgba_q  <= 32'd0;
			endcase
		end
	end

	assign result_valid = valid_q;
	assign command_kind = kind_q;
	assign x_start      = x_start_q;
	assign y_start      = y_start_q;
	assign x_end        = x_end_q;
	assign y_end        = y_end_q;
	assign pause_ms     = pause_q;
	assign rgba_colour  = rgba_q;

endmodule

// ===== hw/rtl/drawing_command_decoder.sv =====
// ----------------------------------------------------------------------------
// Drawing command decoder
// Path: the byte that completes a command pushes it into the command queue; the
// back end then pops it and registers its result until it is transferred.
// Throughput: one byte per cycle while byte_stall is low; bytes stall while the
// two-entry command queue is full.
// Reset: asynchronous, clears cursor, stored point, pen, halt and queue.
// ----------------------------------------------------------------------------
module drawing_command_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [7:0]         stream_byte,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [2:0]         command_kind,
	output logic signed [31:0] x_start,
	output logic signed [31:0] y_start,
	output logic signed [31:0] x_end,
	output logic signed [31:0] y_end,
	output logic signed [35:0] pause_ms,
	output logic [31:0]        rgba_colour
);
	import dcd_pkg::*;

	logic          push;
	cmd_t          push_cmd;
	logic          pop;
	cmd_t          head_cmd;
	queue_status_t queue_status;

	dcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.stream_byte  (stream_byte),
		.queue_status (queue_status),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	dcd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (queue_status)
	);

	dcd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.queue_status (queue_status),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.command_kind (command_kind),
		.x_start      (x_start),
		.y_start      (y_start),
		.x_end        (x_end),
		.y_end        (y_end),
		.pause_ms     (pause_ms),
		.rgba_colour  (rgba_colour)
	);

endmodule
